### src/lfr_pkg.sv
// Shared constants, payload types and controller/datapath signal groups.
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int LIST_AW    = $clog2(NUM_FRAMES);
    localparam int FRAME_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int MODE_W     = 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(64);

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_VICTIM = 2'd0;
    localparam mode_t MODE_PIN    = 2'd1;
    localparam mode_t MODE_UNPIN  = 2'd2;

    // Register index decoded from the word address bit of paddr
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        mode_t              mode;
        logic [FRAME_W-1:0] frame;
    } in_t;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] evicted_frame;
        logic [COUNT_W-1:0] count;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_EVICT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load_req;
        logic rd_tail;
        logic insert;
        logic evict_take;
        logic scan_first;
        logic scan_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  member_hit;
        logic  count_zero;
        logic  below_cap;
        logic  scan_match;
        logic  out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### src/lfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/lfr_ctrl.sv
// Request sequencer: decodes each transfer and steps the datapath through it.
`timescale 1ns / 1ps
`default_nettype none

module lfr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire lfr_pkg::dp_status_t status,
    output lfr_pkg::dp_cmd_t        cmd
);
    import lfr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_RESULT;
                case (status.mode)
                    MODE_VICTIM:
                    begin
                        if (!status.count_zero)
                        begin
                            cmd.rd_tail = 1'b1;
                            state_next  = ST_EVICT;
                        end
                    end
                    MODE_PIN:
                    begin
                        if (status.member_hit)
                        begin
                            cmd.scan_first = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    MODE_UNPIN:
                    begin
                        if (!status.member_hit)
                        begin
                            if (status.below_cap)
                            begin
                                cmd.insert = 1'b1;
                            end
                            else if (!status.count_zero)
                            begin
                                // full: read the oldest entry first
                                cmd.rd_tail = 1'b1;
                                state_next  = ST_EVICT;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_match)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_EVICT:
            begin
                cmd.evict_take = 1'b1;
                cmd.insert     = (status.mode == MODE_UNPIN);
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/lfr_dp.sv
// Datapath: circular recency list in RAM, membership bits, count and result register.
`timescale 1ns / 1ps
`default_nettype none

module lfr_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lfr_pkg::in_t                  in_data,
    input  wire logic [lfr_pkg::COUNT_W-1:0]   capacity,
    input  wire lfr_pkg::dp_cmd_t              cmd,
    output lfr_pkg::dp_status_t                status,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output lfr_pkg::out_t                      out_data
);
    import lfr_pkg::*;

    // request latch
    mode_t              req_mode_reg;
    logic [FRAME_W-1:0] req_frame_reg;

    // list state; logical slot p lives at physical head + p
    logic [LIST_AW-1:0]    head_reg, head_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [NUM_FRAMES-1:0] member_reg, member_next;
    logic [LIST_AW-1:0]    scan_pos_reg, scan_pos_next;
    logic [FRAME_W-1:0]    carry_reg, carry_next;

    logic               found_reg, found_next;
    logic [FRAME_W-1:0] ev_reg, ev_next;

    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;

    logic               ram_we;
    logic [LIST_AW-1:0] ram_waddr;
    logic [FRAME_W-1:0] ram_wdata;
    logic [LIST_AW-1:0] ram_raddr;
    logic [FRAME_W-1:0] ram_rdata;

    logic               scan_match;
    logic [LIST_AW-1:0] tail_addr;

    lfr_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(NUM_FRAMES)
    ) u_list_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign scan_match = (ram_rdata == req_frame_reg);
    assign tail_addr  = head_reg + count_reg[LIST_AW-1:0] - LIST_AW'(1);

    always_comb
    begin
        status.mode       = req_mode_reg;
        status.member_hit = member_reg[req_frame_reg];
        status.count_zero = (count_reg == '0);
        status.below_cap  = (count_reg < capacity);
        status.scan_match = scan_match;
        status.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        if (cmd.rd_tail)
        begin
            ram_raddr = tail_addr;
        end
        else if (cmd.scan_first)
        begin
            ram_raddr = head_reg;
        end
        else
        begin
            ram_raddr = head_reg + scan_pos_reg + LIST_AW'(1);
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        member_next    = member_reg;
        scan_pos_next  = scan_pos_reg;
        carry_next     = carry_reg;
        found_next     = found_reg;
        ev_next        = ev_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg - LIST_AW'(1);
        ram_wdata      = req_frame_reg;

        if (cmd.load_req)
        begin
            found_next = 1'b0;
            ev_next    = '0;
        end

        if (cmd.scan_first)
        begin
            scan_pos_next = '0;
        end

        if (cmd.evict_take)
        begin
            found_next             = 1'b1;
            ev_next                = ram_rdata;
            member_next[ram_rdata] = 1'b0;
            count_next             = count_next - COUNT_W'(1);
        end

        if (cmd.insert)
        begin
            ram_we                     = 1'b1;
            ram_waddr                  = head_reg - LIST_AW'(1);
            ram_wdata                  = req_frame_reg;
            head_next                  = head_reg - LIST_AW'(1);
            member_next[req_frame_reg] = 1'b1;
            count_next                 = count_next + COUNT_W'(1);
        end

        if (cmd.scan_step)
        begin
            // move the entry ahead of this slot one place back
            ram_we    = (scan_pos_reg != '0);
            ram_waddr = head_reg + scan_pos_reg;
            ram_wdata = carry_reg;
            if (scan_match)
            begin
                head_next                  = head_reg + LIST_AW'(1);
                count_next                 = count_reg - COUNT_W'(1);
                member_next[req_frame_reg] = 1'b0;
            end
            else
            begin
                carry_next    = ram_rdata;
                scan_pos_next = scan_pos_reg + LIST_AW'(1);
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.out_load)
        begin
            out_valid_next              = 1'b1;
            out_data_next.found         = found_reg;
            out_data_next.evicted_frame = ev_reg;
            out_data_next.count         = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            member_reg    <= '0;
            scan_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            member_reg    <= member_next;
            scan_pos_reg  <= scan_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_mode_reg  <= in_data.mode;
            req_frame_reg <= in_data.frame;
        end
        carry_reg    <= carry_next;
        found_reg    <= found_next;
        ev_reg       <= ev_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### src/lru_frame_replacer.sv
// Top level: LRU replacement list for buffer frames with APB capacity register.
//
// Requests enter on in_valid/in_stall carrying in_data (mode, frame); each
// transfer produces exactly one result on out_valid/out_stall carrying
// out_data (found, evicted_frame, count). Requests are handled one at a time.
// The sequencer steps each request from idle through dispatch to result,
// where the result loads once the output register is free; the sequencer
// then returns to idle for the next request. Between dispatch and result:
//   no-op or plain unpin insert        no other state
//   victim, or unpin into a full list  evict (one read of the oldest slot)
//   pin of a frame at list slot p      scan (one RAM read per slot walked)
// The list lives in a RAM with one read and one write port, kept as a ring;
// pin walks it from the most recent end and shifts the newer entries back.
// The capacity register (byte address 0) may be written only while idle;
// it resets to 64. Reset empties the list and clears all membership bits.
// A stalled result holds in the output register; the next request is taken
// while it waits, and its own result waits until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module lru_frame_replacer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire lfr_pkg::in_t                in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output lfr_pkg::out_t                    out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lfr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [lfr_pkg::APB_DW-1:0]  pwdata,
    output logic      [lfr_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import lfr_pkg::*;

    logic [COUNT_W-1:0] capacity_reg, capacity_next;
    logic               reg_sel;
    dp_cmd_t            cmd;
    dp_status_t         status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1] == REG_CAPACITY);

    always_comb
    begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            capacity_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    assign prdata = reg_sel ? APB_DW'(capacity_reg) : '0;

    lfr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (status),
        .cmd     (cmd)
    );

    lfr_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .capacity (capacity_reg),
        .cmd      (cmd),
        .status   (status),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

### src/lfr_checker.sv
// Port-level checks for the replacement list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lfr_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_stall,
    input wire logic          out_valid,
    input wire logic          out_stall,
    input wire lfr_pkg::out_t out_data
);
    import lfr_pkg::*;

    // no result shows while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // one request at a time: a transfer closes the input for the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken twice in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    a_no_frame_without_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> (out_data.evicted_frame == '0))
        else $error("evicted frame reported without eviction");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.count <= COUNT_W'(NUM_FRAMES)))
        else $error("count above frame total");

endmodule

bind lru_frame_replacer lfr_checker u_lfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

`default_nettype wire

### bench/lru_frame_replacer_tb.sv
// Self-checking testbench for the LRU frame replacer: directed and random request traffic.
`timescale 1ns / 1ps

module lru_frame_replacer_tb;

    import lfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 100;
    localparam int MAX_REPORTS    = 200;

    localparam logic [APB_AW-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
    localparam mode_t             MODE_UNUSED   = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_t                in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_t               out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [APB_AW-1:0]  paddr     = '0;
    logic [APB_DW-1:0]  pwdata    = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // Shadow of the block: recency order (index 0 most recent), membership, capacity
    logic [FRAME_W-1:0] lru_order[$];
    logic               frame_listed[NUM_FRAMES];
    logic [COUNT_W-1:0] capacity_shadow;
    out_t               pending_results[$];

    int   mismatch_count = 0;
    int   idle_cycles    = 0;
    int   stall_left     = 0;
    logic in_gaps_on     = 1'b1;
    logic out_stalls_on  = 1'b1;

    lru_frame_replacer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch: %s expected %0d got %0d", $time, what, want, got);
    endtask

    // Remove the oldest shadow entry and return its frame number.
    function automatic logic [FRAME_W-1:0] take_oldest();
        logic [FRAME_W-1:0] oldest;
        oldest = lru_order[lru_order.size() - 1];
        lru_order.delete(lru_order.size() - 1);
        frame_listed[oldest] = 1'b0;
        return oldest;
    endfunction

    // Apply one request to the shadow list and return the result it causes.
    function automatic out_t predict_replacement(input in_t req);
        out_t res;
        int   slot;
        res = '0;
        case (req.mode)
            MODE_VICTIM:
            begin
                if (lru_order.size() != 0)
                begin
                    res.found         = 1'b1;
                    res.evicted_frame = take_oldest();
                end
            end
            MODE_PIN:
            begin
                if (frame_listed[req.frame])
                begin
                    slot = 0;
                    while (lru_order[slot] != req.frame)
                        slot++;
                    lru_order.delete(slot);
                    frame_listed[req.frame] = 1'b0;
                end
            end
            MODE_UNPIN:
            begin
                if (!frame_listed[req.frame])
                begin
                    // full list: evict the oldest once, then insert anyway
                    if (lru_order.size() >= int'(capacity_shadow) && lru_order.size() != 0)
                    begin
                        res.found         = 1'b1;
                        res.evicted_frame = take_oldest();
                    end
                    if (lru_order.size() < int'(capacity_shadow) || res.found)
                    begin
                        lru_order.insert(0, req.frame);
                        frame_listed[req.frame] = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.count = COUNT_W'(lru_order.size());
        return res;
    endfunction

    // Present one request and hold it until the transfer completes.
    task automatic send_request(input mode_t mode, input logic [FRAME_W-1:0] frame);
        in_t req;
        req.mode  = mode;
        req.frame = frame;
        if (in_gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_results.push_back(predict_replacement(req));
    endtask

    // Drop valid and wait until every expected result has been taken.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write the capacity register, then read it back. Block must be idle.
    task automatic config_capacity(input logic [COUNT_W-1:0] value);
        logic [APB_DW-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        capacity_shadow = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DW'(value))
            report_mismatch("capacity readback", value, readback);
    endtask

    task automatic test_basic_requests();
        send_request(MODE_VICTIM, 6'd0);    // victim on empty list
        send_request(MODE_PIN, 6'd5);       // pin of absent frame
        send_request(MODE_UNUSED, 6'd63);
        send_request(MODE_UNPIN, 6'd0);
        send_request(MODE_UNPIN, 6'd63);
        send_request(MODE_UNPIN, 6'd42);
        send_request(MODE_UNPIN, 6'd63);    // already listed
        send_request(MODE_PIN, 6'd63);      // pin from the middle
        send_request(MODE_PIN, 6'd63);
        send_request(MODE_VICTIM, 6'd63);
        send_request(MODE_VICTIM, 6'd0);
        send_request(MODE_VICTIM, 6'd21);
        wait_for_results();
    endtask

    task automatic test_capacity_limits();
        config_capacity(7'd0);
        send_request(MODE_UNPIN, 6'd7);     // zero capacity, empty list: no-op
        wait_for_results();
        config_capacity(7'd1);
        send_request(MODE_UNPIN, 6'd7);
        send_request(MODE_UNPIN, 6'd9);     // full: evict then insert
        wait_for_results();
        config_capacity(7'd0);
        send_request(MODE_UNPIN, 6'd11);
        send_request(MODE_VICTIM, 6'd0);
        wait_for_results();
        config_capacity(7'd2);
        send_request(MODE_UNPIN, 6'd1);
        send_request(MODE_UNPIN, 6'd2);
        send_request(MODE_UNPIN, 6'd3);
        wait_for_results();
        // capacity now below the count: unpin evicts only one
        config_capacity(7'd1);
        send_request(MODE_UNPIN, 6'd4);
        send_request(MODE_PIN, 6'd3);
        wait_for_results();
        config_capacity(7'd127);
        send_request(MODE_UNPIN, 6'd20);
        send_request(MODE_UNPIN, 6'd21);
        send_request(MODE_VICTIM, 6'd0);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input logic [COUNT_W-1:0] cap, input int n_items,
                                       input logic idling, input int unpin_pct);
        mode_t              mode;
        logic [FRAME_W-1:0] frame;
        int                 pick;
        int                 sub;
        config_capacity(cap);
        in_gaps_on    = idling;
        out_stalls_on = idling;
        repeat (n_items)
        begin
            pick  = $urandom_range(0, 99);
            sub   = $urandom_range(0, 9);
            frame = FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
            if (pick < unpin_pct)
            begin
                mode = MODE_UNPIN;
                // half the time advance to an absent frame so the list fills
                if ($urandom_range(0, 1) == 0)
                    for (int k = 0; k < NUM_FRAMES && frame_listed[frame]; k++)
                        frame = frame + 1'b1;
            end
            else if (sub < 6)
            begin
                mode = MODE_PIN;
                if (lru_order.size() != 0 && $urandom_range(0, 3) != 0)
                    frame = lru_order[$urandom_range(0, lru_order.size() - 1)];
            end
            else if (sub < 9)
                mode = MODE_VICTIM;
            else
                mode = MODE_UNUSED;
            send_request(mode, frame);
        end
        wait_for_results();
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, count", 0, out_data.count);
            else
            begin
                want = pending_results.pop_front();
                if (out_data.found !== want.found)
                    report_mismatch("found", want.found, out_data.found);
                if (out_data.evicted_frame !== want.evicted_frame)
                    report_mismatch("evicted_frame", want.evicted_frame,
                                    out_data.evicted_frame);
                if (out_data.count !== want.count)
                    report_mismatch("count", want.count, out_data.count);
            end
        end
    end

    // Receiver back-pressure in bursts of random length.
    always @(posedge clk)
    begin
        if (!out_stalls_on)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        foreach (frame_listed[i])
            frame_listed[i] = 1'b0;
        capacity_shadow = CAPACITY_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_requests();
        test_capacity_limits();
        test_random_traffic(7'd64, 250, 1'b1, 45);
        test_random_traffic(7'd1, 150, 1'b1, 50);
        test_random_traffic(7'd8, 250, 1'b1, 50);
        test_random_traffic(7'd33, 250, 1'b1, 55);
        test_random_traffic(7'd64, 250, 1'b1, 80);
        test_random_traffic(7'd127, 150, 1'b1, 60);
        test_random_traffic(7'd2, 150, 1'b1, 50);
        test_random_traffic(7'd0, 100, 1'b1, 50);
        test_random_traffic(COUNT_W'($urandom_range(1, 64)), 250, 1'b1, 55);
        test_random_traffic(COUNT_W'($urandom_range(1, 64)), 150, 1'b0, 55);
        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
